### design/spk_pkg.sv
// Shared types and constants for the Speck 128/128 cipher block.
// No dependencies; used by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package spk_pkg;

    localparam int WORD_W    = 64;
    localparam int ROT_X     = 8;   // rotation applied to the x word
    localparam int ROT_Y     = 3;   // rotation applied to the y word
    localparam int CFG_IDX_W = 1;

    // operation select carried in the func field
    localparam logic FN_ENCRYPT = 1'b0;
    localparam logic FN_DECRYPT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ST_EXPAND,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] block_low;
        logic [WORD_W-1:0] block_high;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] out_low;
        logic [WORD_W-1:0] out_high;
    } t_out;

endpackage

### design/speck_block_cipher.sv
// Speck 128/128 ECB cipher: fully unrolled round pipeline plus key schedule unit.
// Depends on spk_pkg for payload types, register codes and state encoding.
`timescale 1ns / 1ps

// Speck 128/128 in ECB mode. Each block passes through NUM_ROUNDS register
// stages, one cipher round per stage, so one block is accepted per cycle
// while o_stall is low; func selects encrypt or decrypt per transaction.
// Round keys sit in registers, one read at each stage. A write to either
// key register restarts the key schedule, which runs one schedule round
// per cycle; the same expansion runs after reset. o_stall stays high while
// it runs. A stalled output holds the whole pipeline.
module speck_block_cipher #(
    parameter int NUM_ROUNDS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  spk_pkg::t_in                     i_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output spk_pkg::t_out                    o_out,
    input  logic                             i_cfg_we,
    input  logic [spk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spk_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int W     = spk_pkg::WORD_W;
    localparam int CNT_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;

    function automatic logic [2*W-1:0] fwd_round(input logic [W-1:0] x,
                                                 input logic [W-1:0] y,
                                                 input logic [W-1:0] k);
        logic [W-1:0] nx;
        logic [W-1:0] ny;
        nx = (((x >> spk_pkg::ROT_X) | (x << (W - spk_pkg::ROT_X))) + y) ^ k;
        ny = ((y << spk_pkg::ROT_Y) | (y >> (W - spk_pkg::ROT_Y))) ^ nx;
        return {nx, ny};
    endfunction

    function automatic logic [2*W-1:0] inv_round(input logic [W-1:0] x,
                                                 input logic [W-1:0] y,
                                                 input logic [W-1:0] k);
        logic [W-1:0] t;
        logic [W-1:0] nx;
        logic [W-1:0] ny;
        t  = y ^ x;
        ny = (t >> spk_pkg::ROT_Y) | (t << (W - spk_pkg::ROT_Y));
        t  = (x ^ k) - ny;
        nx = (t << spk_pkg::ROT_X) | (t >> (W - spk_pkg::ROT_X));
        return {nx, ny};
    endfunction

    // ---------------- key schedule ----------------
    spk_pkg::t_state r_state, n_state;
    logic [W-1:0]     r_key_low, r_key_high, n_key_low, n_key_high;
    logic [W-1:0]     r_a, r_b;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rk [NUM_ROUNDS];
    logic [2*W-1:0]   w_sched;
    logic             w_last;
    logic             w_expand;

    assign w_last  = (r_cnt == CNT_W'(NUM_ROUNDS - 1));
    assign w_sched = fwd_round(r_a, r_b, {{(W-CNT_W){1'b0}}, r_cnt});

    always_comb begin
        n_key_low  = r_key_low;
        n_key_high = r_key_high;
        if (i_cfg_we) begin
            unique case (spk_pkg::t_cfg_idx'(i_cfg_idx))
                spk_pkg::CFG_KEY_LOW:  n_key_low  = i_cfg_data;
                spk_pkg::CFG_KEY_HIGH: n_key_high = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = spk_pkg::ST_EXPAND;
        end else if (r_state == spk_pkg::ST_EXPAND && w_last) begin
            n_state = spk_pkg::ST_RUN;
        end
    end

    always_comb begin
        w_expand = (r_state == spk_pkg::ST_EXPAND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spk_pkg::ST_EXPAND;
            r_key_low  <= '0;
            r_key_high <= '0;
            r_a        <= '0;
            r_b        <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_key_low  <= n_key_low;
            r_key_high <= n_key_high;
            if (i_cfg_we) begin
                // restart the schedule from the updated key words
                r_a   <= n_key_high;
                r_b   <= n_key_low;
                r_cnt <= '0;
            end else if (w_expand) begin
                r_a   <= w_sched[2*W-1:W];
                r_b   <= w_sched[W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_expand && !i_cfg_we) begin
            r_rk[r_cnt] <= r_b;
        end
    end

    // ---------------- round pipeline ----------------
    logic         w_adv;
    logic         w_accept;
    logic         r_vld [NUM_ROUNDS];
    logic         r_fn  [NUM_ROUNDS];
    logic [W-1:0] r_x   [NUM_ROUNDS];
    logic [W-1:0] r_y   [NUM_ROUNDS];

    assign w_adv    = !(r_vld[NUM_ROUNDS-1] && i_stall);
    assign o_stall  = w_expand || !w_adv;
    assign w_accept = i_valid && !o_stall;

    for (genvar s = 0; s < NUM_ROUNDS; s++) begin : g_stage
        logic           w_vld, w_fn;
        logic [W-1:0]   w_x, w_y, w_k;
        logic [2*W-1:0] w_f, w_i;

        if (s == 0) begin : g_first
            assign w_vld = w_accept;
            assign w_fn  = i_in.func;
            assign w_x   = i_in.block_high;
            assign w_y   = i_in.block_low;
        end else begin : g_next
            assign w_vld = r_vld[s-1];
            assign w_fn  = r_fn[s-1];
            assign w_x   = r_x[s-1];
            assign w_y   = r_y[s-1];
        end

        // decryption walks the schedule backwards
        assign w_k = w_fn ? r_rk[NUM_ROUNDS-1-s] : r_rk[s];
        assign w_f = fwd_round(w_x, w_y, w_k);
        assign w_i = inv_round(w_x, w_y, w_k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_adv) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_fn[s] <= w_fn;
                r_x[s]  <= w_fn ? w_i[2*W-1:W] : w_f[2*W-1:W];
                r_y[s]  <= w_fn ? w_i[W-1:0]   : w_f[W-1:0];
            end
        end
    end

    assign o_valid        = r_vld[NUM_ROUNDS-1];
    assign o_out.out_low  = r_y[NUM_ROUNDS-1];
    assign o_out.out_high = r_x[NUM_ROUNDS-1];

endmodule

### design/spk_checker.sv
// Port-level checks for speck_block_cipher, attached by bind.
// Depends on spk_pkg for the result payload type.
`timescale 1ns / 1ps

module spk_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input spk_pkg::t_out o_out,
    input logic          i_cfg_we
);

    // reset empties the pipeline and starts a key expansion
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_stall))
        else $error("pipeline not empty or input open after reset");

    // a key write blocks input while the schedule is rebuilt
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("input accepted during key expansion");

    // a held result must back-pressure the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input open while output is held");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind speck_block_cipher spk_checker u_spk_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_out    (o_out),
    .i_cfg_we (i_cfg_we)
);

### verif/speck_checker.sv
// Checker for the Speck 128/128 cipher: tracks key writes, predicts each block's result
// and compares every output transaction in order. Depends on spk_pkg.
`timescale 1ns / 1ps

module speck_checker #(
    parameter int NUM_ROUNDS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  spk_pkg::t_in                  i_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  spk_pkg::t_out                 i_out,
    input  logic                          i_cfg_we,
    input  logic [spk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spk_pkg::WORD_W-1:0]    i_cfg_data,
    output int                            o_pending,
    output int                            o_errors
);

    typedef logic [spk_pkg::WORD_W-1:0] t_word;

    t_word         key_word0;
    t_word         key_word1;
    t_word         round_key [NUM_ROUNDS];
    spk_pkg::t_out cipher_results [$];
    int            error_count = 0;

    function automatic t_word rotr(t_word v, int n);
        return (v >> n) | (v << (spk_pkg::WORD_W - n));
    endfunction

    function automatic t_word rotl(t_word v, int n);
        return (v << n) | (v >> (spk_pkg::WORD_W - n));
    endfunction

    // Schedule: the round function with the round index as the key.
    function automatic void expand_schedule();
        t_word a;
        t_word b;
        a = key_word1;
        b = key_word0;
        round_key[0] = b;
        for (int r = 0; r < NUM_ROUNDS - 1; r++) begin
            a = (rotr(a, spk_pkg::ROT_X) + b) ^ t_word'(r);
            b = rotl(b, spk_pkg::ROT_Y) ^ a;
            round_key[r + 1] = b;
        end
    endfunction

    function automatic spk_pkg::t_out speck_transform(spk_pkg::t_in blk);
        t_word         x;
        t_word         y;
        spk_pkg::t_out res;
        x = blk.block_high;
        y = blk.block_low;
        if (blk.func == spk_pkg::FN_ENCRYPT) begin
            for (int r = 0; r < NUM_ROUNDS; r++) begin
                x = (rotr(x, spk_pkg::ROT_X) + y) ^ round_key[r];
                y = rotl(y, spk_pkg::ROT_Y) ^ x;
            end
        end else begin
            for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
                y = rotr(y ^ x, spk_pkg::ROT_Y);
                x = rotl((x ^ round_key[r]) - y, spk_pkg::ROT_X);
            end
        end
        res.out_low  = y;
        res.out_high = x;
        return res;
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : track
        spk_pkg::t_out want;
        if (!i_rst_n) begin
            key_word0 = '0;
            key_word1 = '0;
            expand_schedule();
            cipher_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (spk_pkg::t_cfg_idx'(i_cfg_idx))
                    spk_pkg::CFG_KEY_LOW:  key_word0 = i_cfg_data;
                    spk_pkg::CFG_KEY_HIGH: key_word1 = i_cfg_data;
                    default: ;
                endcase
                expand_schedule();
            end
            if (i_in_valid && !i_in_stall) begin
                cipher_results.push_back(speck_transform(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (cipher_results.size() == 0) begin
                    note_error($sformatf("result %h_%h with none outstanding",
                                         i_out.out_high, i_out.out_low));
                end else begin
                    want = cipher_results.pop_front();
                    if (i_out.out_low !== want.out_low) begin
                        note_error($sformatf("out_low expected %h, got %h",
                                             want.out_low, i_out.out_low));
                    end
                    if (i_out.out_high !== want.out_high) begin
                        note_error($sformatf("out_high expected %h, got %h",
                                             want.out_high, i_out.out_high));
                    end
                end
            end
        end
        o_pending = cipher_results.size();
        o_errors  = error_count;
    end

endmodule

### verif/testbench.sv
// Top of the Speck 128/128 cipher testbench: clock, reset, key writes, block stimulus
// and output pacing. Depends on spk_pkg, speck_block_cipher and speck_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_ROUNDS = 32;
    localparam int ITEMS      = 750;
    localparam int PHASES     = 6;
    localparam int IDLE_LIMIT = 4000;

    typedef logic [spk_pkg::WORD_W-1:0] t_word;

    localparam t_word ZEROS = '0;
    localparam t_word ONES  = '1;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_valid    = 1'b0;
    logic                          i_stall    = 1'b0;
    spk_pkg::t_in                  i_in       = '0;
    logic                          i_cfg_we   = 1'b0;
    logic [spk_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    t_word                         i_cfg_data = '0;
    logic                          o_stall;
    logic                          o_valid;
    spk_pkg::t_out                 o_out;

    int   pending;
    int   errors;
    logic tx_steady   = 1'b0;
    logic rx_steady   = 1'b0;
    int   rx_count    = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    speck_block_cipher #(.NUM_ROUNDS(NUM_ROUNDS)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in      (i_in),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out     (o_out),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    speck_checker #(.NUM_ROUNDS(NUM_ROUNDS)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_stall (o_stall),
        .i_in       (i_in),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // Output side: random stall after each transaction, sometimes while nothing is out,
    // with stretches of no stall at all.
    always @(posedge i_clk) begin : rx_pacing
        int n;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            rx_count <= rx_count + 1;
            if (rx_count % 60 == 59) begin
                rx_steady <= ($urandom_range(0, 2) == 0);
            end
            n = rx_steady ? 0 : $urandom_range(0, 5);
            stall_left <= n;
            i_stall    <= (n != 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left > 1);
        end else if (!o_valid && !rx_steady && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 5);
            stall_left <= n;
            i_stall    <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_word rand_word();
        t_word w;
        case ($urandom_range(0, 15))
            0:       w = ZEROS;
            1:       w = ONES;
            2:       w = t_word'(1) << $urandom_range(0, spk_pkg::WORD_W - 1);
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Valid stays high into the next transaction when there is no gap.
    task automatic send_block(input logic op, input t_word lo, input t_word hi);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_in    <= spk_pkg::t_in'{func: 1'($urandom_range(0, 1)),
                                      block_low: rand_word(),
                                      block_high: rand_word()};
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= spk_pkg::t_in'{func: op, block_low: lo, block_high: hi};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Key writes only with the pipeline empty; then wait out the schedule expansion.
    task automatic write_key(input spk_pkg::t_cfg_idx idx, input t_word value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        do @(posedge i_clk); while (!o_stall);
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero key from reset
        send_block(spk_pkg::FN_ENCRYPT, ZEROS, ZEROS);
        send_block(spk_pkg::FN_DECRYPT, ZEROS, ZEROS);
        send_block(spk_pkg::FN_ENCRYPT, ONES, ONES);
        send_block(spk_pkg::FN_DECRYPT, ONES, ONES);

        // published test key and plaintext, then its ciphertext back
        write_key(spk_pkg::CFG_KEY_LOW, 64'h0706050403020100);
        write_key(spk_pkg::CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        send_block(spk_pkg::FN_ENCRYPT, 64'h7469206564616d20, 64'h6c61766975716520);
        send_block(spk_pkg::FN_DECRYPT, 64'h7860fedf5c570d18, 64'ha65d985179783265);
        send_block(spk_pkg::FN_ENCRYPT, 64'h1, 64'h8000000000000000);
        send_block(spk_pkg::FN_DECRYPT, 64'h8000000000000000, 64'h1);
        tx_steady = 1'b1;
        send_block(spk_pkg::FN_ENCRYPT, {16{4'h5}}, {16{4'ha}});
        send_block(spk_pkg::FN_DECRYPT, {16{4'ha}}, {16{4'h5}});
        send_block(spk_pkg::FN_ENCRYPT, ONES, ZEROS);
        send_block(spk_pkg::FN_DECRYPT, ZEROS, ONES);
        tx_steady = 1'b0;

        write_key(spk_pkg::CFG_KEY_LOW, ONES);
        write_key(spk_pkg::CFG_KEY_HIGH, ONES);
        send_block(spk_pkg::FN_ENCRYPT, ZEROS, ZEROS);
        send_block(spk_pkg::FN_DECRYPT, ZEROS, ZEROS);
        send_block(spk_pkg::FN_ENCRYPT, ONES, ONES);
        send_block(spk_pkg::FN_DECRYPT, ONES, ZEROS);

        write_key(spk_pkg::CFG_KEY_LOW, ZEROS);
        send_block(spk_pkg::FN_ENCRYPT, ONES, ZEROS);
        send_block(spk_pkg::FN_DECRYPT, ZEROS, ONES);

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: begin
                    write_key(spk_pkg::CFG_KEY_LOW, ZEROS);
                    write_key(spk_pkg::CFG_KEY_HIGH, ZEROS);
                end
                1: begin
                    write_key(spk_pkg::CFG_KEY_LOW, ONES);
                    write_key(spk_pkg::CFG_KEY_HIGH, ONES);
                end
                2: write_key(spk_pkg::CFG_KEY_LOW, rand_word());
                3: write_key(spk_pkg::CFG_KEY_HIGH, rand_word());
                default: begin
                    write_key(spk_pkg::CFG_KEY_HIGH, rand_word());
                    write_key(spk_pkg::CFG_KEY_LOW, rand_word());
                end
            endcase
            for (int i = 0; i < ITEMS / PHASES; i++) begin
                if (i % 25 == 0) begin
                    tx_steady = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 99) == 0) begin
                    drain_results();
                end
                send_block($urandom_range(0, 1) == 1 ? spk_pkg::FN_DECRYPT
                                                     : spk_pkg::FN_ENCRYPT,
                           rand_word(), rand_word());
            end
        end

        drain_results();
        repeat (2 * NUM_ROUNDS) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
